// File: rtl/crtg_pkg.sv
// shared widths, constants and word types for the cell restraint target gradient block
package crtg_pkg;

    localparam int AXES        = 3;
    localparam int AXIS_W      = 2;

    localparam int DIFF_W      = 20;
    localparam int MAG_W       = 20;
    localparam int LEN_W       = 22;
    localparam int TGT_W       = 24;
    localparam int WGT_W       = 16;
    localparam int TSUM_W      = 63;
    localparam int GRAD_W      = 64;
    localparam int REG_INDEX_W = 2;

    localparam int SCALE_W     = MAG_W + LEN_W;
    localparam int U_SHIFT     = 16;
    localparam int U_W         = 25;
    localparam int SQ_W        = 39;
    localparam int USQ_W       = 2 * U_W;
    localparam int DL_W        = 60;
    localparam int DSUM_W      = 52;
    localparam int DIST_SHIFT  = 12;
    localparam int DIST_W      = 40;
    localparam int WE_W        = 56;
    localparam int TGT_SHIFT   = 24;
    localparam int GRAD_SHIFT  = 54;

    localparam int HALF_W      = 32;
    localparam int OP_W        = 2 * HALF_W;
    localparam int PP_W        = 2 * HALF_W;
    localparam int PROD_W      = 2 * OP_W;

    localparam logic [SCALE_W-1:0] U_ROUND = SCALE_W'(1) << (U_SHIFT - 1);
    localparam logic [DSUM_W-1:0]  D_ROUND = DSUM_W'(1) << (DIST_SHIFT - 1);

    localparam logic [AXIS_W-1:0] AXIS_A = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_B = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_C = 2'd2;

    localparam logic [REG_INDEX_W-1:0] REG_CELL_A = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_CELL_B = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_CELL_C = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 22'd4096;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [TGT_W-1:0]           tgt;
        logic [WGT_W-1:0]           wgt;
        logic                       last;
    } crtg_item_t;

    typedef struct packed {
        logic [AXES-1:0][LEN_W-1:0] len;
    } crtg_cells_t;

    localparam crtg_cells_t CELLS_RESET = '{len: {AXES{LEN_RESET}}};

endpackage

// File: rtl/cell_restraint_target_gradient.sv
// top level of the cell restraint target and gradient accumulator
// the back end takes one restraint at a time and is bound by the shared 32x32 multiplier
// that builds the target and three gradient products from sixteen partial products
// reset: asynchronous, clears sums, queues and result flag; cell lengths return to 1.0
module cell_restraint_target_gradient
    import crtg_pkg::*;
#(
    parameter int ACC_WIDTH   = 64,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [DIFF_W-1:0] diff_x,
    input  logic signed [DIFF_W-1:0] diff_y,
    input  logic signed [DIFF_W-1:0] diff_z,
    input  logic [TGT_W-1:0]         target_sq_dist,
    input  logic [WGT_W-1:0]         weight,
    input  logic                     last,
    output logic                     empty,
    input  logic                     pop,
    output logic [TSUM_W-1:0]        target_sum,
    output logic signed [GRAD_W-1:0] grad_a,
    output logic signed [GRAD_W-1:0] grad_b,
    output logic signed [GRAD_W-1:0] grad_c,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [REG_INDEX_W-1:0]   cfg_index,
    input  logic [LEN_W-1:0]         cfg_data
);

    crtg_cells_t cells_reg;
    crtg_cells_t cells_next;
    logic        f_valid;
    logic        f_ready;
    crtg_item_t  f_item;
    logic        q_out_valid;
    logic        q_ready;
    crtg_item_t  q_item;
    logic        q_take;

    assign cfg_ready = 1'b1;
    assign q_take    = q_out_valid && q_ready;

    always_comb
    begin
        cells_next = cells_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CELL_A: cells_next.len[AXIS_A] = cfg_data;
                REG_CELL_B: cells_next.len[AXIS_B] = cfg_data;
                REG_CELL_C: cells_next.len[AXIS_C] = cfg_data;
                default:    cells_next = cells_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= CELLS_RESET;
        end
        else
        begin
            cells_reg <= cells_next;
        end
    end

    crtg_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .diff_x         (diff_x),
        .diff_y         (diff_y),
        .diff_z         (diff_z),
        .target_sq_dist (target_sq_dist),
        .weight         (weight),
        .last           (last),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_item       (f_item)
    );

    crtg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_out_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    crtg_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells_reg),
        .q_valid    (q_out_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .pop        (pop),
        .empty      (empty),
        .target_sum (target_sum),
        .grad_a     (grad_a),
        .grad_b     (grad_b),
        .grad_c     (grad_c)
    );

`ifndef SYNTHESIS
    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> !q_take)
        else $error("back end took two words in consecutive cycles");

    a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_out_valid)
        else $error("full raised while the queue holds nothing");

    a_cfg_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index != REG_CELL_A && cfg_index != REG_CELL_B
            && cfg_index != REG_CELL_C |=> $stable(cells_reg))
        else $error("write to an unused register index changed a cell length");
`endif

endmodule

// File: rtl/crtg_front.sv
// front stage: takes restraint words and reduces the differences to magnitudes
module crtg_front
    import crtg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [DIFF_W-1:0] diff_x,
    input  logic signed [DIFF_W-1:0] diff_y,
    input  logic signed [DIFF_W-1:0] diff_z,
    input  logic [TGT_W-1:0]         target_sq_dist,
    input  logic [WGT_W-1:0]         weight,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output crtg_item_t               out_item
);

    function automatic logic [MAG_W-1:0] magnitude(input logic signed [DIFF_W-1:0] v);
        magnitude = v[DIFF_W-1] ? (MAG_W'(~v) + MAG_W'(1)) : MAG_W'(v);
    endfunction

    logic       valid_reg;
    logic       valid_next;
    crtg_item_t item_reg;
    crtg_item_t item_next;
    logic       take;

    assign full      = valid_reg && !out_ready;
    assign take      = push && !full;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next            = 1'b1;
            item_next.mag[AXIS_A] = magnitude(diff_x);
            item_next.mag[AXIS_B] = magnitude(diff_y);
            item_next.mag[AXIS_C] = magnitude(diff_z);
            item_next.tgt         = target_sq_dist;
            item_next.wgt         = weight;
            item_next.last        = last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// File: rtl/crtg_queue.sv
// short word queue between the front stage and the arithmetic back end
module crtg_queue
    import crtg_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  crtg_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output crtg_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    crtg_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr;
    logic             rd;

    assign in_ready  = count_reg != CNT_FULL;
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/crtg_wmul.sv
// 64 by 64 multiplier built from one 32 by 32 multiplier that forms the four partial products in turn
module crtg_wmul
    import crtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OP_W-1:0]   op_a,
    input  logic [OP_W-1:0]   op_b,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    localparam logic [1:0] STEP_LAST = 2'd3;

    logic [OP_W-1:0]   a_reg;
    logic [OP_W-1:0]   a_next;
    logic [OP_W-1:0]   b_reg;
    logic [OP_W-1:0]   b_next;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              busy_reg;
    logic              busy_next;
    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [PROD_W-1:0] pp;
    logic [PROD_W-1:0] pp_placed;
    logic [1:0]        place;

    assign done    = busy_reg && (step_reg == STEP_LAST);
    assign product = acc_reg;

    always_comb
    begin
        a_half = step_reg[0] ? a_reg[OP_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = step_reg[1] ? b_reg[OP_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp     = PROD_W'(PP_W'(a_half) * PP_W'(b_half));
        place  = 2'(step_reg[0]) + 2'(step_reg[1]);
        unique case (place)
            2'd0:    pp_placed = pp;
            2'd1:    pp_placed = pp << HALF_W;
            2'd2:    pp_placed = pp << (2 * HALF_W);
            default: pp_placed = '0;
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + pp_placed;
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

// File: rtl/crtg_back.sv
// back end: residual, target and gradient terms, saturating sums and the result register
module crtg_back
    import crtg_pkg::*;
#(
    parameter int ACC_WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  crtg_cells_t              cells,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  crtg_item_t               q_item,
    input  logic                     pop,
    output logic                     empty,
    output logic [TSUM_W-1:0]        target_sum,
    output logic signed [GRAD_W-1:0] grad_a,
    output logic signed [GRAD_W-1:0] grad_b,
    output logic signed [GRAD_W-1:0] grad_c
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SCALE  = 10'b0000000010,
        ST_SQUARE = 10'b0000000100,
        ST_DIST   = 10'b0000001000,
        ST_RESID  = 10'b0000010000,
        ST_WEIGHT = 10'b0000100000,
        ST_ISSUE  = 10'b0001000000,
        ST_PROD   = 10'b0010000000,
        ST_ACC    = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        OP_TARGET = 2'd0,
        OP_GRAD_A = 2'd1,
        OP_GRAD_B = 2'd2,
        OP_GRAD_C = 2'd3
    } op_t;

    localparam logic signed [ACC_WIDTH-1:0] GRAD_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] GRAD_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    function automatic logic [AXIS_W-1:0] op_axis(input op_t op);
        unique case (op)
            OP_GRAD_B: op_axis = AXIS_B;
            OP_GRAD_C: op_axis = AXIS_C;
            default:   op_axis = AXIS_A;
        endcase
    endfunction

    state_t                      state_reg;
    state_t                      state_next;
    op_t                         op_reg;
    op_t                         op_next;
    crtg_item_t                  item_reg;
    crtg_item_t                  item_next;
    logic [U_W-1:0]              u_reg [AXES];
    logic [U_W-1:0]              u_next [AXES];
    logic [SQ_W-1:0]             sq_reg [AXES];
    logic [SQ_W-1:0]             sq_next [AXES];
    logic [USQ_W-1:0]            usq_reg [AXES];
    logic [USQ_W-1:0]            usq_next [AXES];
    logic [DL_W-1:0]             dl_reg [AXES];
    logic [DL_W-1:0]             dl_next [AXES];
    logic [DIST_W-1:0]           d_reg;
    logic [DIST_W-1:0]           d_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [DIST_W-1:0]           emag_reg;
    logic [DIST_W-1:0]           emag_next;
    logic [WE_W-1:0]             we_reg;
    logic [WE_W-1:0]             we_next;
    logic [ACC_WIDTH-2:0]        acc_tgt_reg;
    logic [ACC_WIDTH-2:0]        acc_tgt_next;
    logic signed [ACC_WIDTH-1:0] acc_grad_reg [AXES];
    logic signed [ACC_WIDTH-1:0] acc_grad_next [AXES];
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic [ACC_WIDTH-2:0]        res_tgt_reg;
    logic [ACC_WIDTH-2:0]        res_tgt_next;
    logic signed [ACC_WIDTH-1:0] res_grad_reg [AXES];
    logic signed [ACC_WIDTH-1:0] res_grad_next [AXES];

    logic                        mul_start;
    logic                        mul_done;
    logic [OP_W-1:0]             mul_a;
    logic [OP_W-1:0]             mul_b;
    logic [PROD_W-1:0]           mul_product;
    logic [AXIS_W-1:0]           axis;
    logic [DSUM_W-1:0]           dsum;
    logic [DIST_W-1:0]           tgt_ext;

    logic [PROD_W-1:0]           tgt_shifted;
    logic                        tgt_big;
    logic [ACC_WIDTH-2:0]        tgt_term;
    logic [ACC_WIDTH-1:0]        tgt_sum;
    logic [ACC_WIDTH-2:0]        tgt_acc_sum;
    logic [PROD_W-1:0]           grad_shifted;
    logic                        grad_big;
    logic signed [ACC_WIDTH-1:0] grad_mag;
    logic signed [ACC_WIDTH-1:0] grad_term;
    logic signed [ACC_WIDTH-1:0] grad_sel;
    logic [ACC_WIDTH:0]          grad_sum;
    logic signed [ACC_WIDTH-1:0] grad_acc_sum;

    crtg_wmul u_wmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign axis    = op_axis(op_reg);
    assign q_ready = state_reg == ST_IDLE;
    assign empty   = !res_valid_reg;
    assign mul_a   = OP_W'(we_reg);
    assign mul_b   = (op_reg == OP_TARGET) ? OP_W'(emag_reg) : OP_W'(dl_reg[axis]);
    assign tgt_ext = DIST_W'(item_reg.tgt);

    assign target_sum = TSUM_W'(res_tgt_reg);
    assign grad_a     = GRAD_W'(res_grad_reg[AXIS_A]);
    assign grad_b     = GRAD_W'(res_grad_reg[AXIS_B]);
    assign grad_c     = GRAD_W'(res_grad_reg[AXIS_C]);

    // term clamp and saturating accumulation
    always_comb
    begin
        tgt_shifted  = mul_product >> TGT_SHIFT;
        tgt_big      = |(tgt_shifted >> (ACC_WIDTH - 1));
        tgt_term     = tgt_big ? '1 : tgt_shifted[ACC_WIDTH-2:0];
        tgt_sum      = {1'b0, acc_tgt_reg} + {1'b0, tgt_term};
        tgt_acc_sum  = tgt_sum[ACC_WIDTH-1] ? '1 : tgt_sum[ACC_WIDTH-2:0];

        grad_shifted = mul_product >> GRAD_SHIFT;
        grad_big     = |(grad_shifted >> (ACC_WIDTH - 1));
        grad_mag     = {1'b0, grad_shifted[ACC_WIDTH-2:0]};
        if (neg_reg)
        begin
            grad_term = grad_big ? GRAD_MIN : -grad_mag;
        end
        else
        begin
            grad_term = grad_big ? GRAD_MAX : grad_mag;
        end
        grad_sel = acc_grad_reg[axis];
        grad_sum = {grad_sel[ACC_WIDTH-1], grad_sel} + {grad_term[ACC_WIDTH-1], grad_term};
        if (grad_sum[ACC_WIDTH] != grad_sum[ACC_WIDTH-1])
        begin
            grad_acc_sum = grad_sum[ACC_WIDTH] ? GRAD_MIN : GRAD_MAX;
        end
        else
        begin
            grad_acc_sum = grad_sum[ACC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        u_next         = u_reg;
        sq_next        = sq_reg;
        usq_next       = usq_reg;
        dl_next        = dl_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        emag_next      = emag_reg;
        we_next        = we_reg;
        acc_tgt_next   = acc_tgt_reg;
        acc_grad_next  = acc_grad_reg;
        res_valid_next = res_valid_reg && !pop;
        res_tgt_next   = res_tgt_reg;
        res_grad_next  = res_grad_reg;
        mul_start      = 1'b0;
        dsum           = DSUM_W'(usq_reg[AXIS_A]) + DSUM_W'(usq_reg[AXIS_B])
                       + DSUM_W'(usq_reg[AXIS_C]) + D_ROUND;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    u_next[k]  = U_W'((SCALE_W'(item_reg.mag[k]) * SCALE_W'(cells.len[k])
                                      + U_ROUND) >> U_SHIFT);
                    sq_next[k] = SQ_W'(item_reg.mag[k]) * SQ_W'(item_reg.mag[k]);
                end
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    usq_next[k] = USQ_W'(u_reg[k]) * USQ_W'(u_reg[k]);
                    dl_next[k]  = DL_W'(sq_reg[k]) * DL_W'(cells.len[k]);
                end
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                d_next     = DIST_W'(dsum >> DIST_SHIFT);
                state_next = ST_RESID;
            end
            ST_RESID:
            begin
                neg_next   = d_reg < tgt_ext;
                emag_next  = (d_reg < tgt_ext) ? (tgt_ext - d_reg) : (d_reg - tgt_ext);
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT:
            begin
                we_next    = WE_W'(item_reg.wgt) * WE_W'(emag_reg);
                op_next    = OP_TARGET;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                if (mul_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (op_reg == OP_TARGET)
                begin
                    acc_tgt_next = tgt_acc_sum;
                end
                else
                begin
                    acc_grad_next[axis] = grad_acc_sum;
                end
                if (op_reg == OP_GRAD_C)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    op_next    = op_t'(op_reg + 2'd1);
                    state_next = ST_ISSUE;
                end
            end
            ST_EMIT:
            begin
                if (!item_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_valid_reg || pop)
                begin
                    res_valid_next = 1'b1;
                    res_tgt_next   = acc_tgt_reg;
                    res_grad_next  = acc_grad_reg;
                    acc_tgt_next   = '0;
                    for (int k = 0; k < AXES; k++)
                    begin
                        acc_grad_next[k] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TARGET;
            acc_tgt_reg   <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                acc_grad_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            acc_tgt_reg   <= acc_tgt_next;
            res_valid_reg <= res_valid_next;
            acc_grad_reg  <= acc_grad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        u_reg        <= u_next;
        sq_reg       <= sq_next;
        usq_reg      <= usq_next;
        dl_reg       <= dl_next;
        d_reg        <= d_next;
        neg_reg      <= neg_next;
        emag_reg     <= emag_next;
        we_reg       <= we_next;
        res_tgt_reg  <= res_tgt_next;
        res_grad_reg <= res_grad_next;
    end

endmodule
